/* hdl/ihg_pkg.sv */
// Shared types and constants for the IPv4 header generator pipeline.
package ihg_pkg;

  // Fixed header fields
  localparam logic [15:0] HDR_BYTES    = 16'd20;
  localparam logic [7:0]  VER_IHL      = 8'h45;
  localparam logic [7:0]  TOS_VALUE    = 8'h00;
  localparam logic [15:0] IDENT_VALUE  = 16'h0001;
  localparam logic [15:0] FLAGS_OFFSET = 16'h4000;
  localparam logic [7:0]  TTL_VALUE    = 8'h40;

  // Constant part of the checksum: word0 top half, word1 both halves, TTL byte
  localparam logic [18:0] CSUM_CONST = 19'({VER_IHL, TOS_VALUE}) + 19'(IDENT_VALUE)
                                     + 19'(FLAGS_OFFSET) + 19'({TTL_VALUE, 8'h00});

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 200;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_OWN_IP      = 2'd0,
    CFG_SUBNET_MASK = 2'd1,
    CFG_GATEWAY_IP  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
  } cfg_t;

  // After stage 1: length done, address halves summed, next hop chosen
  typedef struct packed {
    logic [31:0] dest_ip;
    logic [7:0]  proto_number;
    logic [15:0] total_len;
    logic        length_overflow;
    logic [31:0] next_hop_ip;
    logic [17:0] addr_sum;
  } s1_t;

  // After stage 2: full unfolded ones'-complement sum
  typedef struct packed {
    logic [31:0] dest_ip;
    logic [7:0]  proto_number;
    logic [15:0] total_len;
    logic        length_overflow;
    logic [31:0] next_hop_ip;
    logic [18:0] raw_sum;
  } s2_t;

  // Finished result
  typedef struct packed {
    logic        length_overflow;
    logic [31:0] next_hop_ip;
    logic [31:0] header_word4;
    logic [31:0] header_word3;
    logic [31:0] header_word2;
    logic [31:0] header_word1;
    logic [31:0] header_word0;
  } res_t;

endpackage

/* hdl/ipv4_header_generator_unit.sv */
// IPv4 header generator: request stream in, 20-byte header plus next hop out.
//
// Usage notes:
//  - Slave side (s_axis_*) takes one request per transaction: destination
//    address, protocol number and payload length.
//  - Master side (m_axis_*) gives one result per request, in order: the
//    five header words (first octet in the top bits), the next-hop address
//    and a flag for a total length that does not fit in 16 bits.
//  - Configuration is a plain write port (cfg_we_i, cfg_index_i,
//    cfg_wdata_i); write it only while no request is in flight.
//  - Throughput is one request per cycle while results are taken; the three
//    register stages are length/address sums, checksum accumulation, and
//    carry fold/output.
//  - The pipeline moves as a whole: when the receiver holds m_axis_tready
//    low with a result waiting, every stage holds and s_axis_tready drops
//    until that result is taken. Nothing is lost or repeated.
//  - Reset clears all valid bits and the three configuration registers.
module ipv4_header_generator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i,
  // Request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // dest_ip[31:0], proto_number[39:32], payload_len[55:40]
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata   // header_word0..4 [159:0], next_hop_ip [191:160],
                                      // length_overflow [192], zero fill [199:193]
);
  import ihg_pkg::*;

  cfg_t cfg;
  logic advance;
  logic s1_valid, s2_valid, s3_valid;
  s1_t  s1_data;
  s2_t  s2_data;
  res_t res;

  // Whole pipeline steps unless a result is stuck at the output
  assign advance       = !s3_valid || m_axis_tready;
  assign s_axis_tready = advance;

  ihg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ihg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .valid_i        (s_axis_tvalid),
    .dest_ip_i      (s_axis_tdata[31:0]),
    .proto_number_i (s_axis_tdata[39:32]),
    .payload_len_i  (s_axis_tdata[55:40]),
    .cfg_i          (cfg),
    .valid_o        (s1_valid),
    .data_o         (s1_data)
  );

  ihg_csum u_csum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  ihg_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .cfg_i   (cfg),
    .valid_o (s3_valid),
    .data_o  (res)
  );

  // Output packing, first field lowest
  assign m_axis_tvalid = s3_valid;
  assign m_axis_tdata  = {7'd0, res.length_overflow, res.next_hop_ip,
                          res.header_word4, res.header_word3, res.header_word2,
                          res.header_word1, res.header_word0};

endmodule

/* hdl/ihg_cfg_regs.sv */
// Configuration register file: own address, subnet mask, gateway.
module ihg_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_wdata_i,
  output ihg_pkg::cfg_t cfg_o
);
  import ihg_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode write; unknown index leaves everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OWN_IP:      cfg_d.own_ip      = cfg_wdata_i;
        CFG_SUBNET_MASK: cfg_d.subnet_mask = cfg_wdata_i;
        CFG_GATEWAY_IP:  cfg_d.gateway_ip  = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/ihg_front.sv */
// Stage 1: total length, address half sums and next-hop selection.
module ihg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   dest_ip_i,
  input  logic [7:0]    proto_number_i,
  input  logic [15:0]   payload_len_i,
  input  ihg_pkg::cfg_t cfg_i,
  output logic          valid_o,
  output ihg_pkg::s1_t  data_o
);
  import ihg_pkg::*;

  logic        valid_q;
  s1_t         data_q, data_d;
  logic [16:0] total;

  // Length and checksum partial over both addresses
  always_comb begin
    total                = {1'b0, payload_len_i} + {1'b0, HDR_BYTES};
    data_d.dest_ip       = dest_ip_i;
    data_d.proto_number  = proto_number_i;
    data_d.total_len     = total[15:0];
    data_d.length_overflow = total[16];
    data_d.addr_sum      = 18'(dest_ip_i[31:16]) + 18'(dest_ip_i[15:0])
                         + 18'(cfg_i.own_ip[31:16]) + 18'(cfg_i.own_ip[15:0]);
    // Off-subnet destinations go via the gateway
    if ((dest_ip_i & cfg_i.subnet_mask) != (cfg_i.own_ip & cfg_i.subnet_mask)) begin
      data_d.next_hop_ip = cfg_i.gateway_ip;
    end else begin
      data_d.next_hop_ip = dest_ip_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/ihg_csum.sv */
// Stage 2: adds length, protocol and fixed fields into the raw checksum sum.
module ihg_csum (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  ihg_pkg::s1_t data_i,
  output logic         valid_o,
  output ihg_pkg::s2_t data_o
);
  import ihg_pkg::*;

  logic valid_q;
  s2_t  data_q, data_d;

  // Remaining header halves; protocol is the low byte beside the TTL
  always_comb begin
    data_d.dest_ip         = data_i.dest_ip;
    data_d.proto_number    = data_i.proto_number;
    data_d.total_len       = data_i.total_len;
    data_d.length_overflow = data_i.length_overflow;
    data_d.next_hop_ip     = data_i.next_hop_ip;
    data_d.raw_sum         = 19'(data_i.addr_sum) + 19'(data_i.total_len)
                           + 19'(data_i.proto_number) + CSUM_CONST;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/ihg_out.sv */
// Stage 3: folds the carries, inverts and registers the finished header.
module ihg_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ihg_pkg::s2_t  data_i,
  input  ihg_pkg::cfg_t cfg_i,
  output logic          valid_o,
  output ihg_pkg::res_t data_o
);
  import ihg_pkg::*;

  logic        valid_q;
  res_t        data_q, data_d;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] csum;

  // End-around carry twice, then invert
  always_comb begin
    fold1 = 17'(data_i.raw_sum[15:0]) + 17'(data_i.raw_sum[18:16]);
    fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
    csum  = ~fold2[15:0];

    data_d.header_word0    = {VER_IHL, TOS_VALUE, data_i.total_len};
    data_d.header_word1    = {IDENT_VALUE, FLAGS_OFFSET};
    data_d.header_word2    = {TTL_VALUE, data_i.proto_number, csum};
    data_d.header_word3    = cfg_i.own_ip;
    data_d.header_word4    = data_i.dest_ip;
    data_d.next_hop_ip     = data_i.next_hop_ip;
    data_d.length_overflow = data_i.length_overflow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
